// ===== hw/rtl/assert_macros.svh =====
// assertion helpers
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`define ASSERT_IMPLIES(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("assertion failed");

`define ASSERT_NEXT(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("assertion failed");

`endif

// ===== hw/rtl/rgss_pkg.sv =====
`timescale 1ns / 1ps
package rgss_pkg;
   localparam int unsigned MaxSamples = 4096;
   localparam int unsigned CntW = $clog2(MaxSamples + 1);
   localparam int unsigned SumW = CntW + 16;
   localparam int unsigned SqW = CntW + 32;
   localparam int unsigned NumW = SqW + CntW;
   localparam int unsigned DenW = 2 * CntW;
   localparam int unsigned QuoW = NumW;
   localparam int unsigned RootW = (QuoW + 1) / 2;

   localparam logic [0:0] RegLow = 1'b0;
   localparam logic [0:0] RegHigh = 1'b1;

   localparam logic [1:0] StatusOk = 2'd0;
   localparam logic [1:0] StatusShortSet = 2'd1;
   localparam logic [1:0] StatusFewValid = 2'd2;

   typedef struct packed {
      logic accumulate;
      logic clear;
      logic start_final;
      logic step;
   } cmd_type;

   typedef struct packed {
      logic at_limit;
      logic few_total;
      logic few_valid;
      logic none_valid;
      logic busy_done;
   } status_type;
endpackage

// ===== hw/rtl/rgss_datapath.sv =====
`timescale 1ns / 1ps
`include "assert_macros.svh"
module rgss_datapath (
   input  logic                 clock,
   input  logic                 reset,
   input  rgss_pkg::cmd_type    cmd,
   input  logic [15:0]          sample,
   input  logic [15:0]          low_limit,
   input  logic [15:0]          high_limit,
   output rgss_pkg::status_type stat,
   output logic [15:0]          mean_value,
   output logic [15:0]          max_value,
   output logic [15:0]          min_value,
   output logic [15:0]          std_dev
);
   import rgss_pkg::*;

   logic [CntW-1:0]  total_ff, total_in, valid_ff, valid_in;
   logic [SumW-1:0]  sum_ff, sum_in;
   logic [SqW-1:0]   sq_ff, sq_in;
   logic [15:0]      max_ff, max_in, min_ff, min_in;
   logic             in_range;
   logic [31:0]      sample_sq;
   // final phase: shift-add multiply, restoring divide, digit root
   logic [7:0]       step_ff, step_in;
   logic [NumW-1:0]  num_ff, num_in;
   logic [CntW-1:0]  mult_ff, mult_in;
   logic [DenW-1:0]  den_ff, den_in;
   logic [QuoW-1:0]  quo_ff, quo_in;
   logic [NumW:0]    rem_ff, rem_in;
   logic [SumW-1:0]  msum_ff, msum_in;
   logic [QuoW+1:0]  rrem_ff, rrem_in;
   logic [RootW-1:0] root_ff, root_in;
   logic [1:0]       phase_ff, phase_in;
   logic             done_ff, done_in;
   logic [NumW:0]    rem_try;
   logic [QuoW+1:0]  rrem_sh, rtry;
   logic [2*SumW-1:0] sum_sq;

   assign in_range = (sample > low_limit) && (sample <= high_limit);
   assign sample_sq = sample * sample;
   assign sum_sq = sum_ff * sum_ff;

   assign rem_try = {rem_ff[NumW-1:0], quo_ff[QuoW-1]};
   assign rrem_sh = {rrem_ff[QuoW-1:0], quo_ff[QuoW-1 -: 2]};
   assign rtry = rrem_sh - {(QuoW+2-RootW-2)'(0), root_ff, 2'b01};

   always_comb begin
      total_in = total_ff; valid_in = valid_ff; sum_in = sum_ff; sq_in = sq_ff;
      max_in = max_ff; min_in = min_ff;
      step_in = step_ff; num_in = num_ff; den_in = den_ff; quo_in = quo_ff;
      rem_in = rem_ff; msum_in = msum_ff; rrem_in = rrem_ff; root_in = root_ff;
      mult_in = mult_ff;
      phase_in = phase_ff; done_in = 1'b0;
      if (cmd.accumulate && !stat.at_limit) begin
         total_in = total_ff + 1'b1;
         if (in_range) begin
            valid_in = valid_ff + 1'b1;
            sum_in = sum_ff + SumW'(sample);
            sq_in = sq_ff + SqW'(sample_sq);
            if (valid_ff == '0) begin
               max_in = sample; min_in = sample;
            end else begin
               if (sample > max_ff) max_in = sample;
               if (sample < min_ff) min_in = sample;
            end
         end
      end
      if (cmd.start_final) begin
         phase_in = 2'd0; step_in = '0;
         num_in = '0;
         mult_in = valid_ff;
         den_in = DenW'(valid_ff) * DenW'(valid_ff - 1'b1);
         quo_in = '0; rem_in = '0; rrem_in = '0; root_in = '0;
         // mean division reuses the divider: first pass sum / n
         quo_in = QuoW'(sum_ff);
         msum_in = '0;
      end else if (cmd.step) begin
         case (phase_ff)
            2'd0, 2'd1: begin
               // n times sum of squares, msb first, during the mean pass
               if (phase_ff == 2'd0 && step_ff < 8'(CntW)) begin
                  num_in = {num_ff[NumW-2:0], 1'b0} + (mult_ff[CntW-1] ? NumW'(sq_ff) : '0);
                  mult_in = {mult_ff[CntW-2:0], 1'b0};
               end
               if (rem_try >= (NumW+1)'(phase_ff == 2'd0 ? DenW'(valid_ff) : den_ff)) begin
                  rem_in = rem_try - (NumW+1)'(phase_ff == 2'd0 ? DenW'(valid_ff) : den_ff);
                  quo_in = {quo_ff[QuoW-2:0], 1'b1};
               end else begin
                  rem_in = rem_try;
                  quo_in = {quo_ff[QuoW-2:0], 1'b0};
               end
               step_in = step_ff + 1'b1;
               if (step_ff == 8'(QuoW - 1)) begin
                  step_in = '0; rem_in = '0;
                  if (phase_ff == 2'd0) begin
                     msum_in = SumW'(quo_in);
                     quo_in = num_ff - NumW'(sum_sq);
                     phase_in = 2'd1;
                  end else begin
                     phase_in = 2'd2;
                  end
               end
            end
            2'd2: begin
               quo_in = {quo_ff[QuoW-3:0], 2'b00};
               if (!rtry[QuoW+1]) begin
                  rrem_in = rtry; root_in = {root_ff[RootW-2:0], 1'b1};
               end else begin
                  rrem_in = rrem_sh; root_in = {root_ff[RootW-2:0], 1'b0};
               end
               step_in = step_ff + 1'b1;
               if (step_ff == 8'(RootW - 1)) begin
                  phase_in = 2'd3; done_in = 1'b1;
               end
            end
            default: phase_in = phase_ff;
         endcase
      end
      if (cmd.clear) begin
         total_in = '0; valid_in = '0; sum_in = '0; sq_in = '0;
         max_in = '0; min_in = '1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         total_ff <= '0; valid_ff <= '0; sum_ff <= '0; sq_ff <= '0;
         max_ff <= '0; min_ff <= '1; phase_ff <= 2'd3; done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         total_ff <= total_in; valid_ff <= valid_in; sum_ff <= sum_in; sq_ff <= sq_in;
         max_ff <= max_in; min_ff <= min_in; phase_ff <= phase_in; done_ff <= done_in;
         step_ff <= step_in;
      end
      num_ff <= num_in; den_ff <= den_in; quo_ff <= quo_in; rem_ff <= rem_in;
      msum_ff <= msum_in; rrem_ff <= rrem_in; root_ff <= root_in;
      mult_ff <= mult_in;
   end

   assign stat.at_limit = (total_ff == CntW'(MaxSamples));
   assign stat.few_total = (total_ff < CntW'(2));
   assign stat.few_valid = (valid_ff < CntW'(2));
   assign stat.none_valid = (valid_ff == '0);
   assign stat.busy_done = done_ff;
   // with one valid sample the mean is the sum itself
   assign mean_value = stat.few_valid ? sum_ff[15:0] : msum_ff[15:0];
   assign max_value = max_ff;
   assign min_value = min_ff;
   assign std_dev = (root_ff > RootW'(16'hFFFF)) ? 16'hFFFF : root_ff[15:0];

   `ASSERT_NEXT(a_clear_empties, clock, reset, cmd.clear, total_ff == '0 && valid_ff == '0)
   `ASSERT_IMPLIES(a_valid_le_total, clock, reset, 1'b1, valid_ff <= total_ff)
   `ASSERT_IMPLIES(a_order, clock, reset, valid_ff != '0, min_ff <= max_ff)
endmodule

// ===== hw/rtl/rgss_control.sv =====
`timescale 1ns / 1ps
`include "assert_macros.svh"
module rgss_control (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  logic                 req_tlast,
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   input  rgss_pkg::status_type stat,
   output rgss_pkg::cmd_type    cmd,
   output logic                 load_rsp,
   output logic                 rsp_short
);
   import rgss_pkg::*;

   typedef enum logic [1:0] {Collect, Compute, Emit} state_type;
   state_type state_ff, state_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic req_fire;

   assign req_tready = (state_ff == Collect);
   assign req_fire = req_tvalid && req_tready;
   assign rsp_tvalid = rsp_valid_ff;

   always_comb begin
      state_in = state_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      cmd = '0;
      load_rsp = 1'b0;
      rsp_short = 1'b0;
      cmd.accumulate = req_fire;
      case (state_ff)
         Collect: if (req_fire && req_tlast) state_in = Compute;
         Compute: begin
            // hold until the previous result beat has left
            if (!rsp_valid_ff || rsp_tready) begin
               if (stat.few_valid) begin
                  load_rsp = 1'b1; rsp_short = 1'b1;
                  state_in = Emit;
               end else begin
                  cmd.start_final = 1'b1; state_in = Emit;
               end
            end
         end
         Emit: begin
            if (rsp_short || stat.busy_done) begin
               load_rsp = 1'b1;
            end
            cmd.step = 1'b1;
            if (stat.busy_done) begin
               load_rsp = 1'b1;
            end
         end
         default: state_in = Collect;
      endcase
      if (state_ff == Emit && stat.busy_done) begin
         rsp_valid_in = 1'b1; cmd.clear = 1'b1; state_in = Collect;
      end
      if (rsp_short) begin
         rsp_valid_in = 1'b1; cmd.clear = 1'b1; state_in = Collect;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= Collect; rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in; rsp_valid_ff <= rsp_valid_in;
      end
   end

   `ASSERT_IMPLIES(a_no_take_busy, clock, reset, state_ff != Collect, !req_tready)
   `ASSERT_NEXT(a_last_computes, clock, reset, req_fire && req_tlast, state_ff == Compute)
   `ASSERT_IMPLIES(a_clear_with_rsp, clock, reset, cmd.clear, rsp_valid_in)
endmodule

// ===== hw/rtl/range_gated_sample_statistics.sv =====
`timescale 1ns / 1ps
// Range-gated statistics over sets of Q12.4 samples. A sample counts when it
// lies above low_limit and at or below high_limit. Ordinary beats are taken
// back to back. After the last beat of a set input is stalled for a
// decision, then a 58-step restoring divider for the mean (the n times
// sum-of-squares product is built by shift-add in its first 13 steps), 58
// more steps on the same divider for the variance quotient, a 29-step
// digit-by-digit square root and a load of the result when at least two
// samples are valid; otherwise the result is loaded at the decision itself.
// One result beat is given per set; the next set may be collected while it
// waits, but that set's closing stage is held until the beat has been taken.
module range_gated_sample_statistics (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // sample
   input  logic        req_tlast,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [71:0] rsp_tdata,   // mean, max, min, std_dev, stats_valid, std_status
   input  logic        csr_we,
   input  logic [0:0]  csr_index,
   input  logic [15:0] csr_wdata
);
   import rgss_pkg::*;

   cmd_type     cmd;
   status_type  stat;
   logic        load_rsp, rsp_short;
   logic [15:0] low_ff, high_ff;
   logic [15:0] mean_w, max_w, min_w, sd_w;
   logic [71:0] rsp_ff;
   logic [1:0]  st;

   always_ff @(posedge clock) begin
      if (reset) begin
         low_ff <= 16'd0; high_ff <= 16'd16000;
      end else if (csr_we) begin
         case (csr_index)
            RegLow:  low_ff <= csr_wdata;
            RegHigh: high_ff <= csr_wdata;
            default: low_ff <= low_ff;
         endcase
      end
   end

   rgss_control u_ctl (
      .clock, .reset, .req_tvalid, .req_tready, .req_tlast,
      .rsp_tvalid, .rsp_tready, .stat, .cmd, .load_rsp, .rsp_short
   );

   rgss_datapath u_dp (
      .clock, .reset, .cmd, .sample(req_tdata), .low_limit(low_ff),
      .high_limit(high_ff), .stat, .mean_value(mean_w), .max_value(max_w),
      .min_value(min_w), .std_dev(sd_w)
   );

   assign st = stat.few_total ? StatusShortSet :
               stat.few_valid ? StatusFewValid : StatusOk;

   always_ff @(posedge clock) begin
      if (load_rsp) begin
         rsp_ff[15:0]  <= stat.none_valid ? 16'd0 : mean_w;
         rsp_ff[31:16] <= stat.none_valid ? 16'd0 : max_w;
         rsp_ff[47:32] <= stat.none_valid ? 16'd0 : min_w;
         rsp_ff[63:48] <= rsp_short ? 16'd0 : sd_w;
         rsp_ff[64]    <= !stat.none_valid;
         rsp_ff[66:65] <= st;
         rsp_ff[71:67] <= '0;
      end
   end
   assign rsp_tdata = rsp_ff;
endmodule
